/* rtl/lts_pkg.sv */
package lts_pkg;

  // operation codes
  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_RESERVE = 3'd1;
  localparam logic [2:0] OP_COMMIT  = 3'd2;
  localparam logic [2:0] OP_DISCARD = 3'd3;
  localparam logic [2:0] OP_INVAL   = 3'd4;

  // slot numbers inside the chain; wide enough for the largest slot count
  localparam int SLOT_W = 8;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] lookup_key;
    logic [3:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic        success;
    logic [3:0]  slot_out;
    logic [31:0] hits_seen;
    logic [31:0] misses_seen;
  } out_t;

  // search record that walks down the cell chain
  typedef struct packed {
    logic              vld;
    logic [2:0]        op;
    logic [31:0]       key;
    logic [3:0]        idx;
    logic [4:0]        n;
    logic [31:0]       stamp;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              age_found;
    logic [SLOT_W-1:0] age_slot;
    logic [31:0]       best_age;
  } tok_t;

  // broadcast controls from the controller to every cell
  typedef struct packed {
    logic              clear;
    logic              grant_vld;
    logic [SLOT_W-1:0] grant_slot;
    logic [31:0]       grant_key;
  } cell_ctl_t;

endpackage

/* rtl/lts_cell.sv */
module lts_cell
  import lts_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  tok_t      tin,
  output tok_t      tout
);

  logic [31:0] key;
  logic        valid;
  logic        reserved;
  logic [31:0] age;

  logic in_range;
  logic idx_hit;
  tok_t t;

  assign in_range = 32'(IDX) < {27'b0, tin.n};
  assign idx_hit  = in_range && (SLOT_W'({4'b0, tin.idx}) == SLOT_W'(IDX));

  always_comb begin
    t = tin;
    if (tin.vld && in_range) begin
      case (tin.op)
        OP_LOOKUP: begin
          if (!tin.hit && valid && key == tin.key) begin
            t.hit      = 1'b1;
            t.hit_slot = SLOT_W'(IDX);
          end
        end
        OP_RESERVE: begin
          if (!reserved && !tin.free_found) begin
            if (!valid) begin
              t.free_found = 1'b1;
              t.free_slot  = SLOT_W'(IDX);
            end else if (!tin.age_found || age < tin.best_age) begin
              t.age_found = 1'b1;
              t.age_slot  = SLOT_W'(IDX);
              t.best_age  = age;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.vld <= 1'b0;
    end else begin
      tout <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      reserved <= 1'b0;
      age      <= '0;
    end else if (ctl.clear) begin
      valid    <= 1'b0;
      reserved <= 1'b0;
    end else if (ctl.grant_vld && ctl.grant_slot == SLOT_W'(IDX)) begin
      valid    <= 1'b0;
      reserved <= 1'b1;
    end else if (tin.vld && in_range) begin
      case (tin.op)
        OP_LOOKUP: begin
          if (!tin.hit && valid && key == tin.key) begin
            age <= tin.stamp;
          end
        end
        OP_COMMIT: begin
          if (idx_hit) begin
            valid    <= 1'b1;
            reserved <= 1'b0;
            age      <= tin.stamp;
          end
        end
        OP_DISCARD: begin
          if (idx_hit) begin
            valid    <= 1'b0;
            reserved <= 1'b0;
          end
        end
        OP_INVAL: begin
          valid    <= 1'b0;
          reserved <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // tag key has no reset
  always_ff @(posedge clk) begin
    if (ctl.grant_vld && ctl.grant_slot == SLOT_W'(IDX)) begin
      key <= ctl.grant_key;
    end
  end

endmodule

/* rtl/lru_tag_store_with_reserve_unit.sv */
// channel  | dir | handshake             | payload
// ---------+-----+-----------------------+------------------------------------
// in       | in  | in_valid / in_ready   | in_data  (op, lookup_key, slot_index)
// out      | out | out_valid / out_ready | out_data (success, slot_out, hits, misses)
// cfg      | in  | cfg_valid / cfg_ready | cfg_data (active_slots, 5 bits)
//
// Flow: one transaction at a time; the search record walks the slot chain one
//   cell per cycle, the result is held in res_pend and then loaded into the
//   output register, and only then is the next input transaction taken.
// Reset: rst is synchronous, active high; all slots invalid and unreserved,
//   ages, use clock and hit/miss counters zero, active_slots zero.
// Stalls: the result sits in an output register; the next input transaction
//   is taken while it waits, and a finished search holds until the register frees.
// Config writes are taken only between transactions, win over a waiting input
//   transaction, and empty the store.
module lru_tag_store_with_reserve_unit
  import lts_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state;
  logic [4:0]  active_slots;
  logic [31:0] age_clock;
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  // search record into the head of the chain
  tok_t        tok0;
  tok_t        chain [0:MAX_SLOTS];
  tok_t        tail;

  // pending grant for a reserve, applied in the cycle after the search ends
  logic              grant_vld;
  logic [SLOT_W-1:0] grant_slot;
  logic [31:0]       grant_key;
  cell_ctl_t         ctl;

  out_t        res_pend;
  logic [4:0]  n_eff;

  logic        in_acc;
  logic        cfg_acc;

  // config has priority so an input never pairs with a store flush
  assign in_ready  = (state == S_IDLE) && !rst && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !rst;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // slot count above MAX_SLOTS clamps
  assign n_eff = ({27'b0, active_slots} > 32'(MAX_SLOTS)) ? 5'(MAX_SLOTS) : active_slots;

  assign ctl.clear      = cfg_acc;
  assign ctl.grant_vld  = grant_vld;
  assign ctl.grant_slot = grant_slot;
  assign ctl.grant_key  = grant_key;

  assign chain[0] = tok0;
  assign tail     = chain[MAX_SLOTS];

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    lts_cell #(
      .IDX (i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .tin  (chain[i]),
      .tout (chain[i+1])
    );
  end

  // launch the search record
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0.vld <= 1'b0;
    end else begin
      tok0.vld <= in_acc;
      if (in_acc) begin
        tok0.op         <= in_data.op;
        tok0.key        <= in_data.lookup_key;
        tok0.idx        <= in_data.slot_index;
        tok0.n          <= n_eff;
        tok0.stamp      <= age_clock + 32'd1;
        tok0.hit        <= 1'b0;
        tok0.hit_slot   <= '0;
        tok0.free_found <= 1'b0;
        tok0.free_slot  <= '0;
        tok0.age_found  <= 1'b0;
        tok0.age_slot   <= '0;
        tok0.best_age   <= '0;
      end
    end
  end

  // result of a finished search
  logic        t_ok;
  logic [3:0]  t_slot;
  logic        t_grant;
  logic [SLOT_W-1:0] t_gslot;
  logic        t_hit;
  logic        t_miss;
  logic        t_tick;
  logic        t_idx_ok;

  assign t_idx_ok = {1'b0, tail.idx} < tail.n;

  always_comb begin
    t_ok    = 1'b0;
    t_slot  = 4'd0;
    t_grant = 1'b0;
    t_gslot = '0;
    t_hit   = 1'b0;
    t_miss  = 1'b0;
    t_tick  = 1'b0;
    if (tail.n != 5'd0) begin
      case (tail.op)
        OP_LOOKUP: begin
          if (tail.hit) begin
            t_ok   = 1'b1;
            t_slot = tail.hit_slot[3:0];
            t_hit  = 1'b1;
            t_tick = 1'b1;
          end else begin
            t_miss = 1'b1;
          end
        end
        OP_RESERVE: begin
          if (tail.free_found) begin
            t_ok    = 1'b1;
            t_grant = 1'b1;
            t_gslot = tail.free_slot;
          end else if (tail.age_found) begin
            t_ok    = 1'b1;
            t_grant = 1'b1;
            t_gslot = tail.age_slot;
          end
          t_slot = t_gslot[3:0];
        end
        OP_COMMIT: begin
          t_ok   = t_idx_ok;
          t_tick = t_idx_ok;
        end
        OP_DISCARD: begin
          t_ok = t_idx_ok;
        end
        OP_INVAL: begin
          t_ok = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_slots <= 5'd0;
      age_clock    <= '0;
      hit_total    <= '0;
      miss_total   <= '0;
      grant_vld    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      grant_vld <= (state == S_RUN) && tail.vld && t_grant;
      if (cfg_acc) begin
        active_slots <= cfg_data;
      end
      // output register: load a finished result, else drop when taken
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tail.vld) begin
            state                <= S_DONE;
            age_clock            <= age_clock + {31'b0, t_tick};
            hit_total            <= hit_total + {31'b0, t_hit};
            miss_total           <= miss_total + {31'b0, t_miss};
            res_pend.success     <= t_ok;
            res_pend.slot_out    <= t_slot;
            res_pend.hits_seen   <= hit_total + {31'b0, t_hit};
            res_pend.misses_seen <= miss_total + {31'b0, t_miss};
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data <= res_pend;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // grant payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_RUN && tail.vld) begin
      grant_slot <= t_gslot;
      grant_key  <= tail.key;
    end
  end

  // a search record only leaves the chain while the controller waits for it
  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    tail.vld |-> state == S_RUN)
    else $error("search record left chain outside run state");

  // an accepted transaction launches exactly one record
  a_launch: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> tok0.vld && state == S_RUN)
    else $error("accepted transaction did not launch a search");

  // grant is a single-cycle pulse issued only after a reserve search
  a_grant_pulse: assert property (@(posedge clk) disable iff (rst)
    grant_vld |-> state == S_DONE && !$past(grant_vld))
    else $error("grant pulse malformed");

  // store is not emptied while a search is in the chain
  a_cfg_quiet: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |-> !tok0.vld && !tail.vld)
    else $error("config write during a search");

endmodule

/* bench/tb_lru_tag_store_with_reserve_unit.sv */
`timescale 1ns / 100ps

module tb_lru_tag_store_with_reserve_unit;
  import lts_pkg::*;

  localparam int SLOTS        = 16;
  localparam int LATENCY      = SLOTS + 3;   // wait margin before a register write and before the end of the run
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 650;

  // Scoreboard: keeps its own copy of the tag store and predicts the reply
  // for every accepted request transaction.
  class tag_store_scoreboard;
    logic [31:0] tag_key      [SLOTS];
    bit          key_written  [SLOTS];
    bit          valid_bit    [SLOTS];
    bit          reserved_bit [SLOTS];
    logic [31:0] stamp        [SLOTS];
    logic [31:0] use_clock;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [4:0]  slot_cfg;
    logic [3:0]  last_grant;
    out_t        pending_replies [$];
    int          errors;
    int          replies_seen;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tag_key[i]      = '0;
        key_written[i]  = 1'b0;
        valid_bit[i]    = 1'b0;
        reserved_bit[i] = 1'b0;
        stamp[i]        = '0;
      end
      use_clock    = '0;
      hit_count    = '0;
      miss_count   = '0;
      slot_cfg     = '0;
      last_grant   = '0;
      errors       = 0;
      replies_seen = 0;
    endfunction

    // counts above the array size behave as the full array
    function int slots_in_use();
      return (slot_cfg > SLOTS) ? SLOTS : int'(slot_cfg);
    endfunction

    // a register write empties the store; clock, stamps and counters stay
    function void write_slots(logic [4:0] value);
      slot_cfg = value;
      for (int i = 0; i < SLOTS; i++) begin
        valid_bit[i]    = 1'b0;
        reserved_bit[i] = 1'b0;
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // a key some slot holds, so lookups and reserves collide often
    function logic [31:0] known_key();
      int cand [$];
      for (int i = 0; i < SLOTS; i++)
        if (key_written[i]) cand.push_back(i);
      if (cand.size() == 0) return $urandom();
      return tag_key[cand[$urandom_range(0, cand.size() - 1)]];
    endfunction

    function void note_request(in_t req);
      out_t        rsp;
      int          n;
      int          best;
      bit          found;
      logic [31:0] best_age;
      n        = slots_in_use();
      rsp      = '0;
      found    = 1'b0;
      best     = 0;
      best_age = '0;
      if (n != 0) begin
        case (req.op)
          OP_LOOKUP: begin
            for (int i = 0; i < n; i++) begin
              if (valid_bit[i] && tag_key[i] == req.lookup_key) begin
                use_clock    = use_clock + 32'd1;
                stamp[i]     = use_clock;
                hit_count    = hit_count + 32'd1;
                rsp.success  = 1'b1;
                rsp.slot_out = 4'(i);
                found        = 1'b1;
                break;
              end
            end
            if (!found) miss_count = miss_count + 32'd1;
          end
          OP_RESERVE: begin
            // first free slot wins, else the oldest unreserved one
            for (int i = 0; i < n; i++) begin
              if (!reserved_bit[i]) begin
                if (!valid_bit[i]) begin
                  best  = i;
                  found = 1'b1;
                  break;
                end
                if (!found || stamp[i] < best_age) begin
                  best     = i;
                  best_age = stamp[i];
                  found    = 1'b1;
                end
              end
            end
            if (found) begin
              tag_key[best]      = req.lookup_key;
              key_written[best]  = 1'b1;
              valid_bit[best]    = 1'b0;
              reserved_bit[best] = 1'b1;
              rsp.success        = 1'b1;
              rsp.slot_out       = 4'(best);
              last_grant         = 4'(best);
            end
          end
          OP_COMMIT: begin
            if (req.slot_index < n) begin
              valid_bit[req.slot_index]    = 1'b1;
              reserved_bit[req.slot_index] = 1'b0;
              use_clock                    = use_clock + 32'd1;
              stamp[req.slot_index]        = use_clock;
              rsp.success                  = 1'b1;
            end
          end
          OP_DISCARD: begin
            if (req.slot_index < n) begin
              valid_bit[req.slot_index]    = 1'b0;
              reserved_bit[req.slot_index] = 1'b0;
              rsp.success                  = 1'b1;
            end
          end
          OP_INVAL: begin
            for (int i = 0; i < n; i++) begin
              valid_bit[i]    = 1'b0;
              reserved_bit[i] = 1'b0;
            end
            rsp.success = 1'b1;
          end
          default: ;
        endcase
      end
      rsp.hits_seen   = hit_count;
      rsp.misses_seen = miss_count;
      pending_replies.push_back(rsp);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", replies_seen, what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", got));
        return;
      end
      want = pending_replies.pop_front();
      if (got.success !== want.success)
        report_mismatch($sformatf("success %b, want %b", got.success, want.success));
      if (got.slot_out !== want.slot_out)
        report_mismatch($sformatf("slot_out %0d, want %0d", got.slot_out, want.slot_out));
      if (got.hits_seen !== want.hits_seen)
        report_mismatch($sformatf("hits_seen %h, want %h", got.hits_seen, want.hits_seen));
      if (got.misses_seen !== want.misses_seen)
        report_mismatch($sformatf("misses_seen %h, want %h",
                                  got.misses_seen, want.misses_seen));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_data;

  tag_store_scoreboard sb;
  bit                  src_burst;   // sender runs back to back while set
  int                  cycle_count;

  lru_tag_store_with_reserve_unit #(
    .MAX_SLOTS (SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One request transaction: optional idle gap, then hold valid until taken.
  // With no gap, valid simply stays high into the next transaction.
  task automatic send_request(in_t req);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic send_op(logic [2:0] op, logic [31:0] key, logic [3:0] idx);
    in_t req;
    req.op         = op;
    req.lookup_key = key;
    req.slot_index = idx;
    send_request(req);
  endtask

  // Sender holds off until every reply is back.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Register writes only while the block is idle.
  task automatic write_slot_count(logic [4:0] value);
    wait_for_replies();
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_slots(value);
  endtask

  function automatic in_t random_request();
    in_t req;
    int  pick;
    int  n;
    n              = sb.slots_in_use();
    req.op         = OP_LOOKUP;
    req.lookup_key = $urandom();
    req.slot_index = 4'($urandom_range(0, 15));
    pick           = $urandom_range(0, 99);
    if (pick < 32) begin
      req.op = OP_LOOKUP;
      if ($urandom_range(0, 3) != 0) req.lookup_key = sb.known_key();
    end else if (pick < 57) begin
      req.op = OP_RESERVE;
      if ($urandom_range(0, 2) == 0) req.lookup_key = 32'($urandom_range(0, 7));
    end else if (pick < 80) begin
      req.op = OP_COMMIT;
      if ($urandom_range(0, 3) != 0) req.slot_index = sb.last_grant;
    end else if (pick < 92) begin
      req.op = OP_DISCARD;
      if (n > 0 && $urandom_range(0, 1) == 0) req.slot_index = 4'($urandom_range(0, n - 1));
    end else if (pick < 96) begin
      req.op = OP_INVAL;
    end else begin
      req.op = 3'($urandom_range(OP_INVAL + 1, 7));
    end
    // never let a slot go valid while its key has never been written
    if (req.op == OP_COMMIT && req.slot_index < n && !sb.key_written[req.slot_index])
      req.op = OP_RESERVE;
    return req;
  endfunction

  // Receiver: random stall per reply, with stretches of none.
  initial begin : reply_sink
    int stall;
    int taken;
    out_ready <= 1'b0;
    taken = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = (taken % 100 < 30) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      taken++;
    end
  end

  initial begin : stimulus
    int   slot_plan [9];
    int   per_phase;
    int   sent;
    in_t  req;
    logic [31:0] flow_key;
    slot_plan = '{16, 1, 31, 0, 17, 3, 16, 5, 8};
    sb        = new();
    src_burst = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled after reset: every op answers 0, a lookup counts no miss.
    send_op(OP_LOOKUP,  32'h0000_0000, 4'd0);
    send_op(OP_RESERVE, 32'hFFFF_FFFF, 4'd0);
    send_op(OP_COMMIT,  32'h0000_0000, 4'd0);
    send_op(OP_DISCARD, 32'h0000_0000, 4'd15);
    send_op(OP_INVAL,   32'h0000_0000, 4'd0);
    send_op(3'd7,       32'hFFFF_FFFF, 4'd15);

    // Two slots: fill, exhaust, hit, miss, LRU eviction, range checks.
    write_slot_count(5'd2);
    send_op(OP_RESERVE, 32'hFFFF_FFFF, 4'd0);   // slot 0
    send_op(OP_RESERVE, 32'h0000_0000, 4'd0);   // slot 1
    send_op(OP_RESERVE, 32'h0000_0005, 4'd0);   // all reserved: refused
    send_op(OP_COMMIT,  32'h0000_0000, 4'd0);
    send_op(OP_COMMIT,  32'h0000_0000, 4'd1);
    send_op(OP_LOOKUP,  32'hFFFF_FFFF, 4'd0);   // hit slot 0
    send_op(OP_LOOKUP,  32'h0000_0000, 4'd0);   // hit slot 1, now newest
    send_op(OP_LOOKUP,  32'h1234_5678, 4'd0);   // miss
    send_op(OP_COMMIT,  32'h0000_0000, 4'd2);   // out of range
    send_op(OP_DISCARD, 32'h0000_0000, 4'd15);  // out of range
    send_op(OP_RESERVE, 32'hAAAA_5555, 4'd0);   // evicts oldest, slot 0
    send_op(OP_DISCARD, 32'h0000_0000, 4'd1);
    send_op(OP_COMMIT,  32'h0000_0000, 4'd1);   // commit without a reserve
    send_op(OP_LOOKUP,  32'h0000_0000, 4'd0);   // hit via old key
    send_op(OP_INVAL,   32'h0000_0000, 4'd0);
    send_op(OP_LOOKUP,  32'h0000_0000, 4'd0);   // miss after invalidate

    // Random phases over several slot counts, extremes included.
    per_phase = RANDOM_ITEMS / 9;
    foreach (slot_plan[p]) begin
      write_slot_count(5'(slot_plan[p]));
      sent = 0;
      while (sent < per_phase) begin
        if (sent % 40 == 0) src_burst = ($urandom_range(0, 3) == 0);
        if (sent == per_phase / 2) wait_for_replies();
        if ($urandom_range(0, 3) == 0) begin
          // well-formed fill: reserve, commit the grant, look it up
          flow_key = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 7));
          send_op(OP_RESERVE, flow_key, 4'($urandom_range(0, 15)));
          req = random_request();
          req.op         = OP_COMMIT;
          req.slot_index = sb.last_grant;
          if (req.slot_index < sb.slots_in_use() && !sb.key_written[req.slot_index])
            req.op = OP_RESERVE;
          send_request(req);
          send_op(OP_LOOKUP, flow_key, 4'($urandom_range(0, 15)));
          sent += 3;
        end else begin
          send_request(random_request());
          sent++;
        end
      end
    end

    // Drain, then give the pipeline its latency to show any stray reply.
    wait_for_replies();
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/lts_pkg.sv
rtl/lts_cell.sv
rtl/lru_tag_store_with_reserve_unit.sv
bench/tb_lru_tag_store_with_reserve_unit.sv
